>>> rtl/thermal_aware_slot_scheduler_core_assert.svh
// ----------------------------------------------------------------------------
// thermal aware slot scheduler assertion macros
// shared checker macros, compiled out when NO_ASSERTIONS is defined
// ----------------------------------------------------------------------------
`ifndef THERMAL_AWARE_SLOT_SCHEDULER_CORE_ASSERT_SVH
`define THERMAL_AWARE_SLOT_SCHEDULER_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// property must hold at every clock edge outside reset
`define TSS_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("tss assertion failed");

// condition must never be seen outside reset
`define TSS_NEVER(label, expr) \
   label: assert property (@(posedge clock) disable iff (reset) !(expr)) \
      else $error("tss forbidden condition seen");

`else

`define TSS_ASSERT(label, prop)
`define TSS_NEVER(label, expr)

`endif

`endif

>>> rtl/tss_pkg.sv
// ----------------------------------------------------------------------------
// thermal aware slot scheduler package
// shared widths, codes, types and arithmetic helpers
// ----------------------------------------------------------------------------
package tss_pkg;

   localparam int SLOTS_DEF = 64;
   localparam int SLOT_FW   = 6;
   localparam int ID_W      = 16;
   localparam int HEAT_W    = 7;
   localparam int TEMP_W    = 7;
   localparam int MASK_W    = 64;
   localparam int CSR_IDX_W = 4;

   // request tdata layout
   localparam int REQ_SLOT_LO = 0;
   localparam int REQ_ID_LO   = REQ_SLOT_LO + SLOT_FW;
   localparam int REQ_RUN_LO  = REQ_ID_LO + ID_W;
   localparam int REQ_SLP_LO  = REQ_RUN_LO + MASK_W;
   localparam int REQ_PRI_LO  = REQ_SLP_LO + MASK_W;
   localparam int REQ_BITS    = REQ_PRI_LO + MASK_W;
   localparam int REQ_DATA_W  = ((REQ_BITS + 7) / 8) * 8;

   localparam int RSP_BITS    = 1 + SLOT_FW + 1 + TEMP_W + HEAT_W;
   localparam int RSP_DATA_W  = ((RSP_BITS + 7) / 8) * 8;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_THROTTLE_TEMP   = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_HOT_TEMP        = 4'd1;
   localparam logic [CSR_IDX_W-1:0] REG_WARM_TEMP       = 4'd2;
   localparam logic [CSR_IDX_W-1:0] REG_COOL_HEAT_LIMIT = 4'd3;
   localparam logic [CSR_IDX_W-1:0] REG_WARM_HEAT_LIMIT = 4'd4;
   localparam logic [CSR_IDX_W-1:0] REG_HEAT_GAIN       = 4'd5;
   localparam logic [CSR_IDX_W-1:0] REG_HEAT_LOSS       = 4'd6;
   localparam logic [CSR_IDX_W-1:0] REG_HEAT_CEILING    = 4'd7;

   // register reset values
   localparam logic [TEMP_W-1:0] THROTTLE_TEMP_RST   = 7'd90;
   localparam logic [TEMP_W-1:0] HOT_TEMP_RST        = 7'd80;
   localparam logic [TEMP_W-1:0] WARM_TEMP_RST       = 7'd60;
   localparam logic [HEAT_W-1:0] COOL_HEAT_LIMIT_RST = 7'd30;
   localparam logic [HEAT_W-1:0] WARM_HEAT_LIMIT_RST = 7'd60;
   localparam logic [HEAT_W-1:0] HEAT_GAIN_RST       = 7'd10;
   localparam logic [HEAT_W-1:0] HEAT_LOSS_RST       = 7'd2;
   localparam logic [HEAT_W-1:0] HEAT_CEILING_RST    = 7'd100;

   // temperature model
   localparam logic [TEMP_W-1:0] TEMP_RESET      = 7'd25;
   localparam logic [TEMP_W-1:0] TEMP_MIN        = 7'd20;
   localparam logic [TEMP_W-1:0] TEMP_MAX        = 7'd100;
   localparam logic [TEMP_W-1:0] FAST_COOL_ABOVE = 7'd50;
   localparam int                HEAT_STEP_DIV   = 30;

   typedef struct packed {
      logic [HEAT_W-1:0] heat;
      logic [ID_W-1:0]   id;
      logic              run;
      logic              slp;
      logic              pri;
   } cell_type;

   typedef struct packed {
      logic load;
      logic shift;
      logic wr_heat;
      logic wr_id;
   } cell_ctl_type;

   typedef struct packed {
      logic [TEMP_W-1:0] trip_level;
      logic [TEMP_W-1:0] hot_level;
      logic [TEMP_W-1:0] warm_level;
      logic [HEAT_W-1:0] cool_heat_limit;
      logic [HEAT_W-1:0] warm_heat_limit;
      logic [HEAT_W-1:0] heat_gain;
      logic [HEAT_W-1:0] heat_loss;
      logic [HEAT_W-1:0] heat_ceiling;
   } cfg_type;

   typedef struct packed {
      logic               found;
      logic [SLOT_FW-1:0] slot;
      logic [HEAT_W-1:0]  heat;
   } pick_type;

   // last member (chosen_valid) in the lowest bits
   typedef struct packed {
      logic [RSP_DATA_W-RSP_BITS-1:0] pad;
      logic [HEAT_W-1:0]              chosen_heat;
      logic [TEMP_W-1:0]              temperature;
      logic                           throttled;
      logic [SLOT_FW-1:0]             chosen_slot;
      logic                           chosen_valid;
   } rsp_type;

   // heat / 30 for a 7 bit heat, by compares
   function automatic logic [2:0] heat_step(input logic [HEAT_W-1:0] h);
      logic [2:0] s;
      if (h >= HEAT_W'(HEAT_STEP_DIV * 4))      s = 3'd4;
      else if (h >= HEAT_W'(HEAT_STEP_DIV * 3)) s = 3'd3;
      else if (h >= HEAT_W'(HEAT_STEP_DIV * 2)) s = 3'd2;
      else if (h >= HEAT_W'(HEAT_STEP_DIV))     s = 3'd1;
      else                                      s = 3'd0;
      return s;
   endfunction

   // heat or cool, then clamp to the legal range
   function automatic logic [TEMP_W-1:0] temp_next(input logic [TEMP_W-1:0] t,
                                                   input logic [HEAT_W-1:0] h);
      logic [TEMP_W:0] s;
      if (h != '0)
         s = {1'b0, t} + (TEMP_W+1)'(1) + (TEMP_W+1)'(heat_step(h));
      else if (t > FAST_COOL_ABOVE)
         s = {1'b0, t} - (TEMP_W+1)'(2);
      else
         s = {1'b0, t} - (TEMP_W+1)'(1);
      if (s > {1'b0, TEMP_MAX})      s = {1'b0, TEMP_MAX};
      else if (s < {1'b0, TEMP_MIN}) s = {1'b0, TEMP_MIN};
      return s[TEMP_W-1:0];
   endfunction

endpackage

>>> rtl/tss_cell.sv
// ----------------------------------------------------------------------------
// tss slot cell
// holds one slot's heat, id and round mask bits; passes them to its neighbor
// ----------------------------------------------------------------------------
module tss_cell
   import tss_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  cell_ctl_type      ctl,
   input  logic              load_run,
   input  logic              load_slp,
   input  logic              load_pri,
   input  cell_type          nbr_in,
   input  logic [HEAT_W-1:0] wr_heat,
   input  logic [ID_W-1:0]   wr_id,
   output cell_type          q
);

   cell_type cell_ff, cell_in;

   always_comb begin
      cell_in = cell_ff;
      if (ctl.shift) begin
         cell_in = nbr_in;
      end else if (ctl.load) begin
         cell_in.run = load_run;
         cell_in.slp = load_slp;
         cell_in.pri = load_pri;
      end
      if (ctl.wr_heat) cell_in.heat = wr_heat;
      if (ctl.wr_id)   cell_in.id   = wr_id;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff <= '0;
      end else begin
         cell_ff <= cell_in;
      end
   end

   assign q = cell_ff;

endmodule

>>> rtl/tss_pick.sv
// ----------------------------------------------------------------------------
// tss pick unit
// decays the slot at the head of the ring and keeps the three best candidates
// ----------------------------------------------------------------------------
module tss_pick
   import tss_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               clear,
   input  logic               step,
   input  cell_type           head,
   input  logic [SLOT_FW-1:0] head_slot,
   input  cfg_type            cfg,
   input  logic [TEMP_W-1:0]  temp,
   output cell_type           fed,
   output pick_type           pick
);

   logic              hd_gate;
   logic [HEAT_W-1:0] hd_heat;

   // lowest id priority candidate
   logic               pri_found_ff, pri_found_in;
   logic [SLOT_FW-1:0] pri_slot_ff, pri_slot_in;
   logic [ID_W-1:0]    pri_id_ff, pri_id_in;
   logic [HEAT_W-1:0]  pri_heat_ff, pri_heat_in;
   // coolest candidate
   logic               cool_found_ff, cool_found_in;
   logic [SLOT_FW-1:0] cool_slot_ff, cool_slot_in;
   logic [HEAT_W-1:0]  cool_heat_ff, cool_heat_in;
   // first runnable
   logic               first_found_ff, first_found_in;
   logic [SLOT_FW-1:0] first_slot_ff, first_slot_in;
   logic [HEAT_W-1:0]  first_heat_ff, first_heat_in;

   // decay with floor at zero
   always_comb begin
      hd_heat = head.heat;
      if (head.run || head.slp) begin
         hd_heat = (head.heat > cfg.heat_loss) ? head.heat - cfg.heat_loss : '0;
      end
      hd_gate = !((temp >= cfg.hot_level) && (hd_heat >= cfg.cool_heat_limit)) &&
                !((temp >= cfg.warm_level) && (hd_heat >= cfg.warm_heat_limit));
      fed      = head;
      fed.heat = hd_heat;
   end

   always_comb begin
      pri_found_in   = pri_found_ff;
      pri_slot_in    = pri_slot_ff;
      pri_id_in      = pri_id_ff;
      pri_heat_in    = pri_heat_ff;
      cool_found_in  = cool_found_ff;
      cool_slot_in   = cool_slot_ff;
      cool_heat_in   = cool_heat_ff;
      first_found_in = first_found_ff;
      first_slot_in  = first_slot_ff;
      first_heat_in  = first_heat_ff;
      if (clear) begin
         pri_found_in   = 1'b0;
         cool_found_in  = 1'b0;
         first_found_in = 1'b0;
      end else if (step) begin
         if (head.run && head.pri && hd_gate && (!pri_found_ff || head.id < pri_id_ff)) begin
            pri_found_in = 1'b1;
            pri_slot_in  = head_slot;
            pri_id_in    = head.id;
            pri_heat_in  = hd_heat;
         end
         if (head.run && hd_gate && (!cool_found_ff || hd_heat < cool_heat_ff)) begin
            cool_found_in = 1'b1;
            cool_slot_in  = head_slot;
            cool_heat_in  = hd_heat;
         end
         if (head.run && !first_found_ff) begin
            first_found_in = 1'b1;
            first_slot_in  = head_slot;
            first_heat_in  = hd_heat;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pri_found_ff   <= 1'b0;
         cool_found_ff  <= 1'b0;
         first_found_ff <= 1'b0;
      end else begin
         pri_found_ff   <= pri_found_in;
         cool_found_ff  <= cool_found_in;
         first_found_ff <= first_found_in;
      end
   end

   always_ff @(posedge clock) begin
      pri_slot_ff   <= pri_slot_in;
      pri_id_ff     <= pri_id_in;
      pri_heat_ff   <= pri_heat_in;
      cool_slot_ff  <= cool_slot_in;
      cool_heat_ff  <= cool_heat_in;
      first_slot_ff <= first_slot_in;
      first_heat_ff <= first_heat_in;
   end

   always_comb begin
      priority if (pri_found_ff) begin
         pick = '{found: 1'b1, slot: pri_slot_ff, heat: pri_heat_ff};
      end else if (cool_found_ff) begin
         pick = '{found: 1'b1, slot: cool_slot_ff, heat: cool_heat_ff};
      end else begin
         pick = '{found: first_found_ff, slot: first_slot_ff, heat: first_heat_ff};
      end
   end

endmodule

>>> rtl/thermal_aware_slot_scheduler_core.sv
// ----------------------------------------------------------------------------
// thermal aware slot scheduler core
// picks a task slot per scheduling round under a modeled cpu temperature
// ----------------------------------------------------------------------------
// Each slot's heat and task id live in a ring of SLOTS cells. An allocate
// transfer (req_tuser = 1) writes the slot's id and clears its heat in the
// DONE state, which commits once the output register is free. A round
// transfer (req_tuser = 0)
// loads the three masks into the cells, then the ring rotates once, so every
// slot passes the single pick unit at cell 0, which applies the heat decay,
// the thermal gate and the three candidate compares. A round therefore loads
// the masks, rotates all SLOTS cells past the pick unit, and then commits
// the chosen slot's heat and the new temperature.
// One item is worked on at a time; the response sits in an output register,
// so a new item is accepted while the previous response still waits.
// Configuration writes are taken every cycle (csr_ready is tied high);
// indexes beyond the register list are ignored. No clearing pass after reset.
// ----------------------------------------------------------------------------
`include "thermal_aware_slot_scheduler_core_assert.svh"

module thermal_aware_slot_scheduler_core
   import tss_pkg::*;
#(
   parameter int SLOTS = SLOTS_DEF   // 2 .. 64
) (
   input  logic                  clock,
   input  logic                  reset,
   // request stream
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // slot, task_id, runnable_mask, sleeping_mask, priority_mask, zero pad
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // mode
   input  logic                  req_tuser,
   // response stream
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // chosen_valid, chosen_slot, throttled, temperature, chosen_heat, zero pad
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // register write channel
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [HEAT_W-1:0]     csr_data
);

   localparam int CNT_W = $clog2(SLOTS);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0]         state_ff, state_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               mode_ff;
   logic [SLOT_FW-1:0] slot_ff;
   logic [ID_W-1:0]    id_ff;
   logic [TEMP_W-1:0]  temp_ff, temp_in;
   cfg_type            cfg_ff, cfg_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   logic               req_xfer;
   logic               out_free;
   logic               commit;
   logic               scan_last;
   logic               round_pick;
   logic [HEAT_W:0]    gain_sum;
   logic [HEAT_W-1:0]  cmt_heat;

   logic [MASK_W-1:0]  run_mask, slp_mask, pri_mask;

   cell_type           cells [SLOTS];
   cell_type           fed;
   pick_type           pick;

   // request field unpacking
   assign run_mask = req_tdata[REQ_RUN_LO +: MASK_W];
   assign slp_mask = req_tdata[REQ_SLP_LO +: MASK_W];
   assign pri_mask = req_tdata[REQ_PRI_LO +: MASK_W];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign commit     = (state_ff == ST_DONE) && out_free;
   assign scan_last  = (cnt_ff == CNT_W'(SLOTS - 1));

   // a round that is not throttled and found a runnable slot
   assign round_pick = !mode_ff && (temp_ff < cfg_ff.trip_level) && pick.found;

   // chosen slot gains heat, saturating at the ceiling
   always_comb begin
      gain_sum = {1'b0, pick.heat} + {1'b0, cfg_ff.heat_gain};
      if (gain_sum > {1'b0, cfg_ff.heat_ceiling}) cmt_heat = cfg_ff.heat_ceiling;
      else                                        cmt_heat = gain_sum[HEAT_W-1:0];
      if (mode_ff) cmt_heat = '0;   // allocate clears the slot's heat
   end

   // ring of slot cells; cell 0 feeds the pick unit, which feeds the tail
   for (genvar i = 0; i < SLOTS; i++) begin : g_cell
      cell_ctl_type ctl;
      cell_type     nbr;
      logic         hit;

      assign hit         = (slot_ff == SLOT_FW'(i)) && mode_ff;
      assign ctl.load    = req_xfer && !req_tuser;
      assign ctl.shift   = (state_ff == ST_SCAN);
      assign ctl.wr_heat = commit && (hit || (round_pick && pick.slot == SLOT_FW'(i)));
      assign ctl.wr_id   = commit && hit;

      if (i == SLOTS - 1) begin : g_tail
         assign nbr = fed;
      end else begin : g_body
         assign nbr = cells[i+1];
      end

      tss_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctl      (ctl),
         .load_run (run_mask[i]),
         .load_slp (slp_mask[i]),
         .load_pri (pri_mask[i]),
         .nbr_in   (nbr),
         .wr_heat  (cmt_heat),
         .wr_id    (id_ff),
         .q        (cells[i])
      );
   end

   tss_pick u_pick (
      .clock     (clock),
      .reset     (reset),
      .clear     (req_xfer),
      .step      (state_ff == ST_SCAN),
      .head      (cells[0]),
      .head_slot (SLOT_FW'(cnt_ff)),
      .cfg       (cfg_ff),
      .temp      (temp_ff),
      .fed       (fed),
      .pick      (pick)
   );

   // control sequence
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               cnt_in   = '0;
               state_in = req_tuser ? ST_DONE : ST_SCAN;
            end
         end
         ST_SCAN: begin
            cnt_in = cnt_ff + CNT_W'(1);
            if (scan_last) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // temperature and response at commit
   always_comb begin
      temp_in      = temp_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (commit) begin
         rsp_valid_in             = 1'b1;
         rsp_data_in              = '0;
         rsp_data_in.temperature  = temp_ff;
         if (!mode_ff) begin
            if (temp_ff >= cfg_ff.trip_level) begin
               temp_in               = temp_next(temp_ff, '0);
               rsp_data_in.throttled = 1'b1;
            end else if (pick.found) begin
               temp_in                  = temp_next(temp_ff, cmt_heat);
               rsp_data_in.chosen_valid = 1'b1;
               rsp_data_in.chosen_slot  = pick.slot;
               rsp_data_in.chosen_heat  = cmt_heat;
            end else begin
               temp_in = temp_next(temp_ff, '0);
            end
            rsp_data_in.temperature = temp_in;
         end
      end
   end

   // register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_THROTTLE_TEMP:   cfg_in.trip_level      = csr_data;
            REG_HOT_TEMP:        cfg_in.hot_level       = csr_data;
            REG_WARM_TEMP:       cfg_in.warm_level      = csr_data;
            REG_COOL_HEAT_LIMIT: cfg_in.cool_heat_limit = csr_data;
            REG_WARM_HEAT_LIMIT: cfg_in.warm_heat_limit = csr_data;
            REG_HEAT_GAIN:       cfg_in.heat_gain       = csr_data;
            REG_HEAT_LOSS:       cfg_in.heat_loss       = csr_data;
            REG_HEAT_CEILING:    cfg_in.heat_ceiling    = csr_data;
            default: begin
               cfg_in = cfg_ff;   // index beyond the list is dropped
            end
         endcase
      end
   end

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         temp_ff      <= TEMP_RESET;
         rsp_valid_ff <= 1'b0;
         cfg_ff       <= '{trip_level:      THROTTLE_TEMP_RST,
                           hot_level:       HOT_TEMP_RST,
                           warm_level:      WARM_TEMP_RST,
                           cool_heat_limit: COOL_HEAT_LIMIT_RST,
                           warm_heat_limit: WARM_HEAT_LIMIT_RST,
                           heat_gain:       HEAT_GAIN_RST,
                           heat_loss:       HEAT_LOSS_RST,
                           heat_ceiling:    HEAT_CEILING_RST};
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         temp_ff      <= temp_in;
         rsp_valid_ff <= rsp_valid_in;
         cfg_ff       <= cfg_in;
      end
   end

   // request payload capture, no reset needed
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         mode_ff <= req_tuser;
         slot_ff <= req_tdata[REQ_SLOT_LO +: SLOT_FW];
         id_ff   <= req_tdata[REQ_ID_LO +: ID_W];
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // checks
   `TSS_ASSERT(a_temp_range, (temp_ff >= TEMP_MIN) && (temp_ff <= TEMP_MAX))
   `TSS_NEVER(a_throttle_no_pick, rsp_valid_ff && rsp_data_ff.throttled && rsp_data_ff.chosen_valid)
   `TSS_ASSERT(a_scan_runs, ((state_ff == ST_SCAN) && !scan_last) |=> (state_ff == ST_SCAN))
   `TSS_ASSERT(a_scan_ends, ((state_ff == ST_SCAN) && scan_last) |=> (state_ff == ST_DONE))
   `TSS_NEVER(a_pick_range, commit && round_pick && (pick.slot > SLOT_FW'(SLOTS - 1)))

endmodule
